>>> rtl/srff_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srff_pkg
// Shared types and codes for the first-free slot registry.
// ----------------------------------------------------------------------------
package srff_pkg;

    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_GET = 2'd1;
    localparam logic [1:0] MODE_DEL = 2'd2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = 1;
    localparam int CMDQ_CNT_W = 2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [5:0]  slot_index;
        logic [31:0] record_data;
    } srff_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  given_index;
        logic [31:0] read_data;
    } srff_rsp_t;

    typedef enum logic [1:0] {
        KIND_ADD,
        KIND_GET,
        KIND_DEL,
        KIND_REJECT
    } srff_kind_t;

    typedef struct packed {
        srff_kind_t  kind;
        logic [5:0]  slot_index;
        logic [31:0] record_data;
    } srff_cmd_t;

    typedef enum logic {
        BS_FETCH,
        BS_REPLY
    } srff_bstate_t;

endpackage

>>> rtl/srff_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srff_front
// Accepts requests, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module srff_front #(
    parameter int TOTAL_SLOTS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  srff_pkg::srff_req_t  req,
    output logic                 cmd_valid,
    input  logic                 cmd_pop,
    output srff_pkg::srff_cmd_t  cmd
);
    import srff_pkg::*;

    srff_cmd_t               q_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0]   wr_ptr_reg;
    logic [CMDQ_PTR_W-1:0]   wr_ptr_next;
    logic [CMDQ_PTR_W-1:0]   rd_ptr_reg;
    logic [CMDQ_PTR_W-1:0]   rd_ptr_next;
    logic [CMDQ_CNT_W-1:0]   count_reg;
    logic [CMDQ_CNT_W-1:0]   count_next;
    logic                    do_push;
    logic                    do_pop;
    srff_cmd_t               new_cmd;

    assign full      = (count_reg == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;

    always_comb
    begin
        new_cmd.slot_index  = req.slot_index;
        new_cmd.record_data = req.record_data;
        unique case (req.mode)
            MODE_ADD: new_cmd.kind = KIND_ADD;
            MODE_GET: new_cmd.kind = KIND_GET;
            MODE_DEL: new_cmd.kind = KIND_DEL;
            default:  new_cmd.kind = KIND_REJECT;
        endcase
        if (new_cmd.kind != KIND_ADD && 32'(req.slot_index) >= TOTAL_SLOTS)
        begin
            new_cmd.kind = KIND_REJECT;
        end
    end

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // hold queued commands
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

>>> rtl/srff_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srff_back
// Carries out commands against the used marks and the record store, and
// holds each result until it is taken.
// ----------------------------------------------------------------------------
module srff_back #(
    parameter int DATA_WIDTH  = 32,
    parameter int TOTAL_SLOTS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_pop,
    input  srff_pkg::srff_cmd_t  cmd,
    output logic                 empty,
    input  logic                 pop,
    output srff_pkg::srff_rsp_t  rsp
);
    import srff_pkg::*;

    localparam int SLOT_W = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;

    logic [DATA_WIDTH-1:0]  store_mem [TOTAL_SLOTS];
    logic [DATA_WIDTH-1:0]  store_q;
    logic                   mem_we;
    logic [SLOT_W-1:0]      mem_waddr;
    logic [SLOT_W-1:0]      mem_raddr;

    srff_bstate_t           state_reg;
    srff_bstate_t           state_next;
    logic [TOTAL_SLOTS-1:0] used_reg;
    logic [TOTAL_SLOTS-1:0] used_next;
    logic [1:0]             pend_status_reg;
    logic [1:0]             pend_status_next;
    logic [5:0]             pend_index_reg;
    logic [5:0]             pend_index_next;
    logic                   pend_get_reg;
    logic                   pend_get_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    srff_rsp_t              out_reg;
    srff_rsp_t              out_next;

    logic                   free_found;
    logic [SLOT_W-1:0]      free_slot;
    logic [SLOT_W-1:0]      cmd_slot;

    assign empty    = !out_valid_reg;
    assign rsp      = out_reg;
    assign cmd_slot = SLOT_W'(cmd.slot_index);

    always_comb
    begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = TOTAL_SLOTS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_found = 1'b1;
                free_slot  = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        used_next        = used_reg;
        pend_status_next = pend_status_reg;
        pend_index_next  = pend_index_reg;
        pend_get_next    = pend_get_reg;
        out_valid_next   = out_valid_reg;
        out_next         = out_reg;
        cmd_pop          = 1'b0;
        mem_we           = 1'b0;
        mem_waddr        = free_slot;
        mem_raddr        = cmd_slot;

        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            BS_FETCH:
            begin
                if (cmd_valid && !out_valid_reg)
                begin
                    cmd_pop         = 1'b1;
                    state_next      = BS_REPLY;
                    pend_get_next   = 1'b0;
                    pend_index_next = cmd.slot_index;
                    unique case (cmd.kind)
                        KIND_ADD:
                        begin
                            if (free_found)
                            begin
                                used_next[free_slot] = 1'b1;
                                mem_we               = 1'b1;
                                pend_status_next     = ST_DONE;
                                pend_index_next      = 6'(free_slot);
                            end
                            else
                            begin
                                pend_status_next = ST_FULL;
                                pend_index_next  = '0;
                            end
                        end
                        KIND_GET:
                        begin
                            if (used_reg[cmd_slot])
                            begin
                                pend_status_next = ST_DONE;
                                pend_get_next    = 1'b1;
                            end
                            else
                            begin
                                pend_status_next = ST_EMPTY;
                            end
                        end
                        KIND_DEL:
                        begin
                            if (used_reg[cmd_slot])
                            begin
                                used_next[cmd_slot] = 1'b0;
                                pend_status_next    = ST_DONE;
                            end
                            else
                            begin
                                pend_status_next = ST_EMPTY;
                            end
                        end
                        KIND_REJECT:
                        begin
                            pend_status_next = ST_EMPTY;
                        end
                    endcase
                end
            end
            BS_REPLY:
            begin
                out_valid_next       = 1'b1;
                out_next.status      = pend_status_reg;
                out_next.given_index = pend_index_reg;
                out_next.read_data   = pend_get_reg ? 32'(store_q) : '0;
                state_next           = BS_FETCH;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BS_FETCH;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_status_reg <= pend_status_next;
        pend_index_reg  <= pend_index_next;
        pend_get_reg    <= pend_get_next;
        out_reg         <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= DATA_WIDTH'(cmd.record_data);
        end
        store_q <= store_mem[mem_raddr];
    end

endmodule

>>> rtl/slot_registry_first_free_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_registry_first_free_core
// Registry of fixed-size records in SLOTS_PER_BLOCK * MAX_BLOCKS slots. An
// add stores its record in the lowest-numbered free slot and returns that
// slot, or reports full; a get returns the record of a slot in use; a delete
// frees a slot in use. Requests enter a two-entry command queue and are
// executed one at a time: the back end first does the used-mark update and
// the record store access, then loads the result register. The back end
// starts a command only once the previous result has been taken, while the
// queue can go on accepting requests until it is full. Used marks are
// flip-flops cleared by reset, so the block takes requests right after reset
// with no clearing pass.
// ----------------------------------------------------------------------------
module slot_registry_first_free_core #(
    parameter int DATA_WIDTH      = 32,
    parameter int SLOTS_PER_BLOCK = 16,
    parameter int MAX_BLOCKS      = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  srff_pkg::srff_req_t  req,
    output logic                 empty,
    input  logic                 pop,
    output srff_pkg::srff_rsp_t  rsp
);
    import srff_pkg::*;

    localparam int TOTAL_SLOTS = SLOTS_PER_BLOCK * MAX_BLOCKS;

    logic      cmd_valid;
    logic      cmd_pop;
    srff_cmd_t cmd;

    srff_front #(
        .TOTAL_SLOTS (TOTAL_SLOTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd)
    );

    srff_back #(
        .DATA_WIDTH  (DATA_WIDTH),
        .TOTAL_SLOTS (TOTAL_SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .empty     (empty),
        .pop       (pop),
        .rsp       (rsp)
    );

    a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command taken from empty queue");

    a_no_pop_while_result_waits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> empty)
        else $error("command started while result still waiting");

    a_full_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && rsp.status == ST_FULL) |-> (rsp.given_index == '0 && rsp.read_data == '0))
        else $error("full result carries index or data");

    a_data_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && rsp.read_data != '0) |-> rsp.status == ST_DONE)
        else $error("read data on a failed request");

endmodule

>>> tb/sv/slot_registry_first_free_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_registry_first_free_core_test
// Self-checking bench for the first-free slot registry. A short table of
// add/get/delete requests covers empty, unused-mode and full cases, then
// random traffic swings occupancy between empty and full. Each response is
// checked field by field against its table entry or a behavioral model,
// with random idle cycles on both queue sides and one long response stall.
// ----------------------------------------------------------------------------
module slot_registry_first_free_core_test;
    import srff_pkg::*;

    localparam int BLK_SLOTS      = 16;
    localparam int BLK_COUNT      = 4;
    localparam int TOTAL_SLOTS    = BLK_SLOTS * BLK_COUNT;
    localparam int RANDOM_ITEMS   = 1600;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AFTER     = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int IDLE_PCT       = 32;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct {
        srff_req_t item;
        int        reps;
        bit        has_want;
        srff_rsp_t want;
    } plan_row_t;

    logic      clk   = 1'b0;
    logic      rst_n = 1'b0;
    logic      push  = 1'b0;
    logic      pop   = 1'b0;
    srff_req_t req   = '0;
    logic      full;
    logic      empty;
    srff_rsp_t rsp;

    bit [TOTAL_SLOTS-1:0] slot_used;
    logic [31:0]          slot_record [TOTAL_SLOTS];
    int                   open_blocks;
    int                   free_count [BLK_COUNT];

    srff_rsp_t rsp_due [$];
    plan_row_t plan [$];
    int        accepted    = 0;
    int        errors      = 0;
    int        idle_cycles = 0;
    bit        steady      = 1'b0;
    bit        hold_done   = 1'b0;

    slot_registry_first_free_core #(
        .DATA_WIDTH      (32),
        .SLOTS_PER_BLOCK (BLK_SLOTS),
        .MAX_BLOCKS      (BLK_COUNT)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .req   (req),
        .empty (empty),
        .pop   (pop),
        .rsp   (rsp)
    );

    always #4 clk = ~clk;

    function automatic srff_rsp_t registry_apply(input srff_req_t r);
        srff_rsp_t o;
        int        b;
        int        s;
        int        slot;
        bit        placed;
        o.status      = ST_EMPTY;
        o.given_index = r.slot_index;
        o.read_data   = '0;
        if (r.mode == MODE_ADD)
        begin
            placed        = 1'b0;
            o.status      = ST_FULL;
            o.given_index = '0;
            for (b = 0; b < BLK_COUNT && !placed; b++)
            begin
                if (b >= open_blocks)
                begin
                    for (s = 0; s < BLK_SLOTS; s++)
                        slot_used[b * BLK_SLOTS + s] = 1'b0;
                    free_count[b] = BLK_SLOTS;
                    open_blocks   = b + 1;
                end
                if (free_count[b] != 0)
                begin
                    for (s = 0; s < BLK_SLOTS && !placed; s++)
                    begin
                        slot = b * BLK_SLOTS + s;
                        if (!slot_used[slot])
                        begin
                            slot_used[slot]   = 1'b1;
                            slot_record[slot] = r.record_data;
                            free_count[b]--;
                            placed        = 1'b1;
                            o.status      = ST_DONE;
                            o.given_index = slot[5:0];
                        end
                    end
                end
            end
        end
        else if (r.mode == MODE_GET || r.mode == MODE_DEL)
        begin
            if (int'(r.slot_index) < open_blocks * BLK_SLOTS && slot_used[r.slot_index])
            begin
                o.status = ST_DONE;
                if (r.mode == MODE_GET)
                    o.read_data = slot_record[r.slot_index];
                else
                begin
                    slot_used[r.slot_index] = 1'b0;
                    free_count[r.slot_index / BLK_SLOTS]++;
                end
            end
        end
        return o;
    endfunction

    function automatic plan_row_t plan_row(input logic [1:0] mode, input logic [5:0] idx,
                                           input logic [31:0] data, input int reps,
                                           input bit has_want, input logic [1:0] st,
                                           input logic [5:0] gi, input logic [31:0] rd);
        plan_row_t p;
        p.item.mode        = mode;
        p.item.slot_index  = idx;
        p.item.record_data = data;
        p.reps             = reps;
        p.has_want         = has_want;
        p.want.status      = st;
        p.want.given_index = gi;
        p.want.read_data   = rd;
        return p;
    endfunction

    function automatic srff_req_t random_req(input bit add_heavy);
        srff_req_t r;
        int        pick;
        int        start;
        int        k;
        pick          = $urandom_range(99);
        r.slot_index  = 6'($urandom_range(TOTAL_SLOTS - 1));
        r.record_data = $urandom;
        case ($urandom_range(15))
            0: r.record_data = '0;
            1: r.record_data = '1;
            default: ;
        endcase
        if (pick >= 97)
            r.mode = MODE_UNUSED;
        else if (pick < (add_heavy ? 60 : 25))
            r.mode = MODE_ADD;
        else
        begin
            r.mode = (pick % 2 == 0) ? MODE_GET : MODE_DEL;
            if ($urandom_range(3) != 0)
            begin
                start = $urandom_range(TOTAL_SLOTS - 1);
                for (k = 0; k < TOTAL_SLOTS; k++)
                begin
                    if (slot_used[(start + k) % TOTAL_SLOTS])
                    begin
                        r.slot_index = 6'((start + k) % TOTAL_SLOTS);
                        break;
                    end
                end
            end
        end
        return r;
    endfunction

    task automatic send_req(input srff_req_t r, input bit has_want, input srff_rsp_t want);
        srff_rsp_t got;
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        req  <= r;
        do
            @(posedge clk);
        while (full);
        got = registry_apply(r);
        rsp_due.push_back(has_want ? want : got);
        accepted++;
    endtask

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("%0t watchdog: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        srff_rsp_t want;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                if (rsp_due.size() == 0)
                begin
                    $display("%0t unexpected transfer: expected none, got %h", $time, rsp);
                    errors++;
                end
                else
                begin
                    want = rsp_due.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $display("%0t status: expected %0d, got %0d",
                                 $time, want.status, rsp.status);
                        errors++;
                    end
                    if (rsp.given_index !== want.given_index)
                    begin
                        $display("%0t given_index: expected %0d, got %0d",
                                 $time, want.given_index, rsp.given_index);
                        errors++;
                    end
                    if (rsp.read_data !== want.read_data)
                    begin
                        $display("%0t read_data: expected %h, got %h",
                                 $time, want.read_data, rsp.read_data);
                        errors++;
                    end
                end
            end
            if (!hold_done && accepted >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            pop <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial
    begin
        srff_req_t item;
        srff_rsp_t none;
        int        i;
        int        k;
        bit        add_heavy;

        none        = '0;
        slot_used   = '0;
        open_blocks = 1;
        foreach (free_count[b])
            free_count[b] = BLK_SLOTS;
        foreach (slot_record[s])
            slot_record[s] = '0;

        plan.push_back(plan_row(MODE_GET,    6'd0,  32'h0,        1, 1, ST_EMPTY, 6'd0,  32'h0));
        plan.push_back(plan_row(MODE_DEL,    6'd63, 32'h0,        1, 1, ST_EMPTY, 6'd63, 32'h0));
        plan.push_back(plan_row(MODE_UNUSED, 6'd63, 32'hFFFFFFFF, 1, 1, ST_EMPTY, 6'd63, 32'h0));
        plan.push_back(plan_row(MODE_ADD,    6'd0,  32'h0,        1, 1, ST_DONE,  6'd0,  32'h0));
        plan.push_back(plan_row(MODE_ADD,    6'd63, 32'hFFFFFFFF, 1, 1, ST_DONE,  6'd1,  32'h0));
        plan.push_back(plan_row(MODE_GET,    6'd1,  32'h0,        1, 1, ST_DONE,  6'd1,
                                32'hFFFFFFFF));
        plan.push_back(plan_row(MODE_GET,    6'd0,  32'hFFFFFFFF, 1, 1, ST_DONE,  6'd0,  32'h0));
        plan.push_back(plan_row(MODE_GET,    6'd16, 32'h0,        1, 1, ST_EMPTY, 6'd16, 32'h0));
        plan.push_back(plan_row(MODE_DEL,    6'd0,  32'h0,        1, 1, ST_DONE,  6'd0,  32'h0));
        plan.push_back(plan_row(MODE_GET,    6'd0,  32'h0,        1, 1, ST_EMPTY, 6'd0,  32'h0));
        plan.push_back(plan_row(MODE_DEL,    6'd0,  32'h0,        1, 1, ST_EMPTY, 6'd0,  32'h0));
        plan.push_back(plan_row(MODE_ADD,    6'd0,  32'hA5A5A5A5, 1, 1, ST_DONE,  6'd0,  32'h0));
        plan.push_back(plan_row(MODE_ADD,    6'd0,  32'h0,        62, 0, ST_DONE, 6'd0,  32'h0));
        plan.push_back(plan_row(MODE_ADD,    6'd5,  32'h12345678, 1, 1, ST_FULL,  6'd0,  32'h0));
        plan.push_back(plan_row(MODE_GET,    6'd63, 32'h0,        1, 0, ST_DONE,  6'd63, 32'h0));
        plan.push_back(plan_row(MODE_DEL,    6'd63, 32'h0,        1, 1, ST_DONE,  6'd63, 32'h0));
        plan.push_back(plan_row(MODE_GET,    6'd63, 32'h0,        1, 1, ST_EMPTY, 6'd63, 32'h0));
        plan.push_back(plan_row(MODE_DEL,    6'd17, 32'h0,        1, 1, ST_DONE,  6'd17, 32'h0));
        plan.push_back(plan_row(MODE_ADD,    6'd0,  32'h5555AAAA, 1, 1, ST_DONE,  6'd17, 32'h0));
        plan.push_back(plan_row(MODE_ADD,    6'd0,  32'h0,        1, 1, ST_DONE,  6'd63, 32'h0));
        plan.push_back(plan_row(MODE_GET,    6'd17, 32'h0,        1, 1, ST_DONE,  6'd17,
                                32'h5555AAAA));
        plan.push_back(plan_row(MODE_ADD,    6'd0,  32'hFFFFFFFF, 1, 1, ST_FULL,  6'd0,  32'h0));
        plan.push_back(plan_row(MODE_UNUSED, 6'd0,  32'h0,        1, 1, ST_EMPTY, 6'd0,  32'h0));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            for (k = 0; k < plan[i].reps; k++)
            begin
                item = plan[i].item;
                if (plan[i].reps > 1)
                    item.record_data = $urandom;
                send_req(item, plan[i].has_want, plan[i].want);
            end
        end

        add_heavy = 1'b0;
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 150 == 0)
                add_heavy = !add_heavy;
            steady = (i >= 700 && i < 1000);
            send_req(random_req(add_heavy), 1'b0, none);
        end
        push   <= 1'b0;
        steady = 1'b0;

        while (rsp_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && rsp_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
